// ===== rtl/core/i2cmrt_pkg.sv =====
// shared types and constants for the i2c master register transfer block
`timescale 1ns / 1ps
package i2cmrt_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_DATA  = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [1:0] CFG_UNIT_TICKS  = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

	localparam logic [15:0] UNIT_TICKS_RST  = 16'd100;
	localparam logic [9:0]  ACK_TIMEOUT_RST = 10'd250;

	typedef struct packed {
		logic [15:0] unit_ticks;
		logic [9:0]  ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       want_data;
		logic [7:0] read_data;
		logic       read_valid;
		logic       read_last;
		logic       done_res;
		logic       error;
	} res_t;

endpackage

// ===== rtl/core/i2cmrt_cfg.sv =====
// configuration registers: bus timing unit and ack timeout
`timescale 1ns / 1ps
module i2cmrt_cfg
	import i2cmrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	logic [15:0] unit_ticks_q;
	logic [9:0]  ack_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= UNIT_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_data;
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg.unit_ticks  = unit_ticks_q;
	assign cfg.ack_timeout = ack_timeout_q;

endmodule

// ===== rtl/core/i2cmrt_engine.sv =====
// bus sequencer: phase state, bit and byte counters, result decode per request
`timescale 1ns / 1ps
module i2cmrt_engine
	import i2cmrt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] action,
	input  logic [6:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] xfer_length,
	input  logic [7:0] data_byte,
	input  logic       sda_in,
	input  cfg_t       cfg,
	output res_t       res
);

	localparam logic [4:0] PH_IDLE  = 5'd0;
	localparam logic [4:0] PH_SA1   = 5'd1;
	localparam logic [4:0] PH_SA2   = 5'd2;
	localparam logic [4:0] PH_SB1   = 5'd3;
	localparam logic [4:0] PH_SB2   = 5'd4;
	localparam logic [4:0] PH_TSET  = 5'd5;
	localparam logic [4:0] PH_THI   = 5'd6;
	localparam logic [4:0] PH_TLO   = 5'd7;
	localparam logic [4:0] PH_AREL  = 5'd8;
	localparam logic [4:0] PH_AHI   = 5'd9;
	localparam logic [4:0] PH_APOLL = 5'd10;
	localparam logic [4:0] PH_WDATA = 5'd11;
	localparam logic [4:0] PH_RLO   = 5'd12;
	localparam logic [4:0] PH_RHI   = 5'd13;
	localparam logic [4:0] PH_ML1   = 5'd14;
	localparam logic [4:0] PH_ML2   = 5'd15;
	localparam logic [4:0] PH_MH1   = 5'd16;
	localparam logic [4:0] PH_MH2   = 5'd17;
	localparam logic [4:0] PH_PL1   = 5'd18;
	localparam logic [4:0] PH_PL2   = 5'd19;
	localparam logic [4:0] PH_PH1   = 5'd20;
	localparam logic [4:0] PH_PH2   = 5'd21;

	localparam logic [1:0] ST_ADDR_W = 2'd0;
	localparam logic [1:0] ST_REG    = 2'd1;
	localparam logic [1:0] ST_DATA   = 2'd2;
	localparam logic [1:0] ST_ADDR_R = 2'd3;

	logic [4:0]  phase_q,     n_phase;
	logic [15:0] unit_timer_q, n_timer;
	logic [3:0]  bit_index_q, n_bit;
	logic [7:0]  shift_q,     n_shift;
	logic [7:0]  bytes_left_q, n_bytes;
	logic [9:0]  tcount_q,    n_tcount;
	logic [6:0]  dev_q,       n_dev;
	logic [7:0]  reg_q,       n_reg;
	logic        read_mode_q, n_read_mode;
	logic        err_flag_q,  n_err_flag;
	logic [1:0]  stage_q,     n_stage;

	logic [15:0] timer_inc;
	logic        elapsed;
	logic        fail;
	logic        r_valid;
	logic        r_last;
	logic        r_done;
	logic        r_err;
	logic        scl;
	logic        sdal;
	logic        drv;

	assign timer_inc = unit_timer_q + 16'd1;
	assign elapsed   = (timer_inc >= cfg.unit_ticks);
	assign fail      = sda_in && (tcount_q >= cfg.ack_timeout);

	always_comb begin
		n_phase     = phase_q;
		n_timer     = unit_timer_q;
		n_bit       = bit_index_q;
		n_shift     = shift_q;
		n_bytes     = bytes_left_q;
		n_tcount    = tcount_q;
		n_dev       = dev_q;
		n_reg       = reg_q;
		n_read_mode = read_mode_q;
		n_err_flag  = err_flag_q;
		n_stage     = stage_q;
		r_valid     = 1'b0;
		r_last      = 1'b0;
		r_done      = 1'b0;
		r_err       = 1'b0;

		if (action == ACT_WRITE || action == ACT_READ) begin
			if (phase_q == PH_IDLE) begin
				n_dev       = dev_addr;
				n_reg       = reg_addr;
				n_bytes     = xfer_length;
				n_read_mode = (action == ACT_READ);
				n_err_flag  = 1'b0;
				n_tcount    = '0;
				n_bit       = '0;
				n_shift     = {dev_addr, 1'b0};
				n_stage     = ST_ADDR_W;
				n_phase     = PH_SA1;
				n_timer     = '0;
			end
		end else if (action == ACT_DATA) begin
			if (phase_q == PH_WDATA) begin
				n_shift = data_byte;
				n_bit   = '0;
				n_stage = ST_DATA;
				n_phase = PH_TSET;
				n_timer = '0;
			end
		end else if (phase_q == PH_APOLL) begin
			if (sda_in && !fail)
				n_tcount = tcount_q + 10'd1;
			if (!sda_in || fail) begin
				n_timer = '0;
				if (fail && (stage_q == ST_ADDR_W || stage_q == ST_DATA)) begin
					n_err_flag = 1'b1;
					n_phase    = PH_PL1;
				end else begin
					unique case (stage_q)
						ST_ADDR_W: begin
							n_shift = reg_q;
							n_bit   = '0;
							n_stage = ST_REG;
							n_phase = PH_TSET;
						end
						ST_REG: begin
							if (read_mode_q) begin
								n_stage = ST_ADDR_R;
								n_phase = PH_SA1;
							end else if (bytes_left_q == 8'd0) begin
								n_phase = PH_PL1;
							end else begin
								n_stage = ST_DATA;
								n_phase = PH_WDATA;
							end
						end
						ST_DATA: begin
							n_bytes = bytes_left_q - 8'd1;
							n_phase = (n_bytes == 8'd0) ? PH_PL1 : PH_WDATA;
						end
						default: begin
							n_bit   = '0;
							n_phase = (bytes_left_q == 8'd0) ? PH_PL1 : PH_RLO;
						end
					endcase
				end
			end
		end else if (phase_q != PH_IDLE && phase_q != PH_WDATA) begin
			if (!elapsed) begin
				n_timer = timer_inc;
			end else begin
				n_timer = '0;
				unique case (phase_q)
					PH_SB2: begin
						if (stage_q == ST_ADDR_R)
							n_shift = {dev_q, 1'b1};
						n_bit   = '0;
						n_phase = PH_TSET;
					end
					PH_TLO: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_index_q + 4'd1;
						n_phase = (n_bit >= 4'd8) ? PH_AREL : PH_TSET;
					end
					PH_AHI: begin
						n_tcount = '0;
						n_phase  = PH_APOLL;
					end
					PH_RHI: begin
						n_shift = {shift_q[6:0], sda_in};
						n_bit   = bit_index_q + 4'd1;
						if (n_bit >= 4'd8) begin
							r_valid = 1'b1;
							r_last  = (bytes_left_q == 8'd1);
							n_phase = PH_ML1;
						end else begin
							n_phase = PH_RLO;
						end
					end
					PH_MH2: begin
						n_bytes = bytes_left_q - 8'd1;
						n_bit   = '0;
						n_phase = (n_bytes == 8'd0) ? PH_PL1 : PH_RLO;
					end
					PH_PH2: begin
						r_done  = 1'b1;
						r_err   = err_flag_q;
						n_phase = PH_IDLE;
					end
					default: n_phase = phase_q + 5'd1;
				endcase
			end
		end
	end

	// bus levels after this request
	always_comb begin
		unique case (n_phase)
			PH_SA1, PH_SA2:          begin scl = 1'b1; sdal = 1'b1; drv = 1'b1; end
			PH_SB1, PH_SB2:          begin scl = 1'b1; sdal = 1'b0; drv = 1'b1; end
			PH_TSET, PH_TLO:         begin scl = 1'b0; sdal = n_shift[7]; drv = 1'b1; end
			PH_THI:                  begin scl = 1'b1; sdal = n_shift[7]; drv = 1'b1; end
			PH_AREL:                 begin scl = 1'b0; sdal = 1'b1; drv = 1'b1; end
			PH_AHI:                  begin scl = 1'b1; sdal = 1'b1; drv = 1'b1; end
			PH_APOLL, PH_RHI:        begin scl = 1'b1; sdal = 1'b1; drv = 1'b0; end
			PH_WDATA, PH_RLO:        begin scl = 1'b0; sdal = 1'b1; drv = 1'b0; end
			PH_ML1, PH_ML2: begin
				scl = 1'b0; sdal = (n_bytes == 8'd1); drv = 1'b1;
			end
			PH_MH1, PH_MH2: begin
				scl = 1'b1; sdal = (n_bytes == 8'd1); drv = 1'b1;
			end
			PH_PL1, PH_PL2:          begin scl = 1'b0; sdal = 1'b0; drv = 1'b1; end
			PH_PH1, PH_PH2:          begin scl = 1'b1; sdal = 1'b1; drv = 1'b1; end
			default:                 begin scl = 1'b1; sdal = 1'b1; drv = 1'b0; end
		endcase
	end

	assign res.scl_level  = scl;
	assign res.sda_level  = sdal;
	assign res.sda_drive  = drv;
	assign res.busy_res   = (n_phase != PH_IDLE);
	assign res.want_data  = (n_phase == PH_WDATA);
	assign res.read_data  = r_valid ? n_shift : 8'd0;
	assign res.read_valid = r_valid;
	assign res.read_last  = r_last;
	assign res.done_res   = r_done;
	assign res.error      = r_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			unit_timer_q <= '0;
			bit_index_q  <= '0;
			shift_q      <= '0;
			bytes_left_q <= '0;
			tcount_q     <= '0;
			dev_q        <= '0;
			reg_q        <= '0;
			read_mode_q  <= 1'b0;
			err_flag_q   <= 1'b0;
			stage_q      <= ST_ADDR_W;
		end else if (accept) begin
			phase_q      <= n_phase;
			unit_timer_q <= n_timer;
			bit_index_q  <= n_bit;
			shift_q      <= n_shift;
			bytes_left_q <= n_bytes;
			tcount_q     <= n_tcount;
			dev_q        <= n_dev;
			reg_q        <= n_reg;
			read_mode_q  <= n_read_mode;
			err_flag_q   <= n_err_flag;
			stage_q      <= n_stage;
		end
	end

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && r_done) |=> (phase_q == PH_IDLE))
		else $error("done without return to idle");

	a_wdata_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WDATA) |-> (stage_q == ST_DATA && !read_mode_q))
		else $error("data wait outside write data stage");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= 4'd8)
		else $error("bit counter out of range");

endmodule

// ===== rtl/core/i2cmrt_outq.sv =====
// two-entry result queue between the sequencer and the output channel
`timescale 1ns / 1ps
module i2cmrt_outq
	import i2cmrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);

	res_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue overflow");

endmodule

// ===== rtl/core/i2c_master_register_transfer.sv =====
// top level of the i2c master register transfer block
// the result of each accepted request is registered in the result queue and leaves it in order
// throughput: one request per cycle while in_stall is low; the sequencer state advances once per request
// a two-entry result queue keeps requests flowing while one result waits at the output
// reset: asynchronous, active low; sequencer idle, unit_ticks 100, ack_timeout 250
`timescale 1ns / 1ps
module i2c_master_register_transfer
	import i2cmrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [6:0]  dev_addr,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  xfer_length,
	input  logic [7:0]  data_byte,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        want_data,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        read_last,
	output logic        done_res,
	output logic        error
);

	cfg_t cfg;
	res_t res;
	res_t out_data;
	logic full;
	logic accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	i2cmrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cmrt_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.dev_addr    (dev_addr),
		.reg_addr    (reg_addr),
		.xfer_length (xfer_length),
		.data_byte   (data_byte),
		.sda_in      (sda_in),
		.cfg         (cfg),
		.res         (res)
	);

	i2cmrt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign scl_level  = out_data.scl_level;
	assign sda_level  = out_data.sda_level;
	assign sda_drive  = out_data.sda_drive;
	assign busy_res   = out_data.busy_res;
	assign want_data  = out_data.want_data;
	assign read_data  = out_data.read_data;
	assign read_valid = out_data.read_valid;
	assign read_last  = out_data.read_last;
	assign done_res   = out_data.done_res;
	assign error      = out_data.error;

endmodule
